// ===== src/l1s_pkg.sv =====
// Shared types and constants for the L1Sync port state machine.
package l1s_pkg;

    typedef enum logic [2:0] {
        ST_DISABLED     = 3'd0,
        ST_IDLE         = 3'd1,
        ST_PEER_SEEN    = 3'd2,
        ST_CONFIG_MATCH = 3'd3,
        ST_UP           = 3'd4
    } t_state;

    // Item function codes
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_SIGNAL = 2'd1;
    localparam logic [1:0] FUNC_EVAL   = 2'd2;

    // Port roles
    localparam logic [1:0] ROLE_MASTER = 2'd1;
    localparam logic [1:0] ROLE_SLAVE  = 2'd2;

    // Configuration register indexes
    localparam int          CFG_IDX_W       = 3;
    localparam int          CFG_DATA_W      = 8;
    localparam logic [2:0]  CFG_SYNC_ENABLE = 3'd0;
    localparam logic [2:0]  CFG_TX_COH      = 3'd1;
    localparam logic [2:0]  CFG_RX_COH      = 3'd2;
    localparam logic [2:0]  CFG_CONGRUENT   = 3'd3;
    localparam logic [2:0]  CFG_LOG_INTVL   = 3'd4;
    localparam logic [2:0]  CFG_RX_TIMEOUT  = 3'd5;

    // Bit positions within the configured / active triples
    localparam int BIT_TX   = 0;
    localparam int BIT_RX   = 1;
    localparam int BIT_CONG = 2;

    localparam int RX_TIMER_W = 26;
    localparam int TX_TIMER_W = 18;

    typedef struct packed {
        logic [1:0] func;
        logic       new_role;
        logic [1:0] port_role;
        logic       link_up;
        logic       pll_locked;
        logic [2:0] peer_cfg;
        logic [2:0] peer_act;
    } t_item;

    typedef struct packed {
        logic              sync_enable;
        logic [2:0]        local_cfg;
        logic signed [3:0] log_interval;
        logic [7:0]        receipt_timeout;
    } t_cfg;

    typedef struct packed {
        t_state                  state;
        logic                    alive;
        logic [2:0]              local_act;
        logic [2:0]              peer_cfg;
        logic [2:0]              peer_act;
        logic [RX_TIMER_W-1:0]   rx_timer;
        logic [TX_TIMER_W-1:0]   tx_timer;
        logic                    mode;
    } t_core;

    typedef struct packed {
        logic send;
        logic lock_on;
        logic lock_off;
        logic entered_up;
    } t_cmd;

endpackage

// ===== src/l1sync_port_state_machine.sv =====
// Top level of the L1Sync port state machine with its handshake stages.
//
// One item (tick, received signaling or evaluation) is taken per clock unless
// both stages are full: the item is held in an input register, the next port
// state is worked out from it in one pass of logic and written together with
// the result flags into the result register and the state registers. The port
// state, local active bits, peer alive flag and transmit timer shown on the
// result ports are the state registers themselves, which change only when a
// result is loaded, so they always belong to the result on offer. The input
// register keeps taking items while a result waits downstream, until both
// stages are full. Configuration writes are accepted in any cycle and should
// only be made while no item is in flight.
module l1sync_port_state_machine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_func,
    input  logic                           i_new_role,
    input  logic [1:0]                     i_port_role,
    input  logic                           i_link_up,
    input  logic                           i_pll_locked,
    input  logic                           i_peer_tx_cfg,
    input  logic                           i_peer_rx_cfg,
    input  logic                           i_peer_cong_cfg,
    input  logic                           i_peer_tx_act,
    input  logic                           i_peer_rx_act,
    input  logic                           i_peer_cong_act,
    // result output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_sync_state,
    output logic                           o_send_signal,
    output logic                           o_pll_lock_on,
    output logic                           o_pll_lock_off,
    output logic                           o_accurate_mode,
    output logic                           o_entered_up,
    output logic                           o_tx_coh_active,
    output logic                           o_rx_coh_active,
    output logic                           o_cong_active,
    output logic                           o_peer_alive,
    output logic [17:0]                    o_next_delay,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [l1s_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [l1s_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import l1s_pkg::*;

    t_cfg  r_cfg;
    t_item r_item;
    logic  r_item_valid;
    t_core r_core, n_core;
    t_cmd  r_cmd, n_cmd;
    logic  r_out_valid;

    logic  advance;

    // the input stage moves on whenever the result register is free or drains
    assign advance    = r_item_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_item_valid || advance;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_enable     <= 1'b1;
            r_cfg.local_cfg       <= 3'b111;
            r_cfg.log_interval    <= 4'sd0;
            r_cfg.receipt_timeout <= 8'd3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_ENABLE: r_cfg.sync_enable          <= i_cfg_data[0];
                CFG_TX_COH:      r_cfg.local_cfg[BIT_TX]    <= i_cfg_data[0];
                CFG_RX_COH:      r_cfg.local_cfg[BIT_RX]    <= i_cfg_data[0];
                CFG_CONGRUENT:   r_cfg.local_cfg[BIT_CONG]  <= i_cfg_data[0];
                CFG_LOG_INTVL:   r_cfg.log_interval         <= i_cfg_data[3:0];
                CFG_RX_TIMEOUT:  r_cfg.receipt_timeout      <= i_cfg_data;
                default:         r_cfg                      <= r_cfg;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_item_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.func       <= i_func;
            r_item.new_role   <= i_new_role;
            r_item.port_role  <= i_port_role;
            r_item.link_up    <= i_link_up;
            r_item.pll_locked <= i_pll_locked;
            r_item.peer_cfg   <= {i_peer_cong_cfg, i_peer_rx_cfg, i_peer_tx_cfg};
            r_item.peer_act   <= {i_peer_cong_act, i_peer_rx_act, i_peer_tx_act};
        end
    end

    l1s_step u_step (
        .i_item (r_item),
        .i_cfg  (r_cfg),
        .i_core (r_core),
        .o_core (n_core),
        .o_cmd  (n_cmd)
    );

    // port state: updated exactly when a result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core <= '0;
        end else if (advance) begin
            r_core <= n_core;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sync_state    = r_core.state;
    assign o_send_signal   = r_cmd.send;
    assign o_pll_lock_on   = r_cmd.lock_on;
    assign o_pll_lock_off  = r_cmd.lock_off;
    assign o_accurate_mode = r_core.mode;
    assign o_entered_up    = r_cmd.entered_up;
    assign o_tx_coh_active = r_core.local_act[BIT_TX];
    assign o_rx_coh_active = r_core.local_act[BIT_RX];
    assign o_cong_active   = r_core.local_act[BIT_CONG];
    assign o_peer_alive    = r_core.alive;
    assign o_next_delay    = r_core.tx_timer;

endmodule

// ===== src/l1s_step.sv =====
// Next-state logic of the L1Sync port machine for one transfer.
module l1s_step (
    input  l1s_pkg::t_item i_item,
    input  l1s_pkg::t_cfg  i_cfg,
    input  l1s_pkg::t_core i_core,
    output l1s_pkg::t_core o_core,
    output l1s_pkg::t_cmd  o_cmd
);
    import l1s_pkg::*;

    logic [3:0]            shamt;
    logic [TX_TIMER_W-1:0] interval;
    logic [RX_TIMER_W-1:0] rx_load;

    logic       master, slave, cong, link;
    logic       xmit, lon, loff, alive;
    logic [2:0] la, pa;
    logic       cfg_match, act_match;
    logic       f_idle, f_la, f_cm, f_up;
    t_state     s0, s_new;
    t_core      ev_core;
    t_cmd       ev_cmd;

    // interval = 4 << (log + 8); offset-binary of the signed log gives the shift
    assign shamt    = {~i_cfg.log_interval[3], i_cfg.log_interval[2:0]};
    assign interval = TX_TIMER_W'(4) << shamt;
    assign rx_load  = RX_TIMER_W'(i_cfg.receipt_timeout) << (5'(shamt) + 5'd2);

    assign master = (i_item.port_role == ROLE_MASTER);
    assign slave  = (i_item.port_role == ROLE_SLAVE);
    assign cong   = i_cfg.local_cfg[BIT_CONG];
    assign link   = i_item.link_up;

    // Evaluation event
    always_comb begin
        la    = i_core.local_act;
        alive = i_core.alive;
        xmit  = 1'b0;
        lon   = 1'b0;
        loff  = 1'b0;

        if (i_item.new_role && cong) begin
            xmit = 1'b1;
            if (master) begin
                la[BIT_RX] = 1'b0;
                loff       = 1'b1;
            end
        end
        // receive timer ran out: peer lost
        if (alive && (i_core.rx_timer == '0)) begin
            alive = 1'b0;
            if (slave) loff = 1'b1;
            xmit = 1'b1;
        end
        if (slave && cong) begin
            if (i_item.pll_locked) begin
                if (!la[BIT_RX]) xmit = 1'b1;
                la[BIT_RX] = 1'b1;
            end else begin
                la[BIT_RX] = 1'b0;
            end
        end
        if (master && cong) begin
            la[BIT_RX] = i_core.peer_act[BIT_TX] & i_core.peer_act[BIT_RX] & la[BIT_TX];
        end
        la[BIT_TX]   = link;
        la[BIT_CONG] = link;

        pa = ((i_core.state == ST_DISABLED) || (i_core.state == ST_IDLE)) ?
             3'b000 : i_core.peer_act;

        cfg_match = (i_cfg.local_cfg == i_core.peer_cfg);
        act_match = ((i_cfg.local_cfg & la & pa) == i_cfg.local_cfg);

        // disable override first, then lost peer forces idle
        s0 = i_core.state;
        if (!i_cfg.sync_enable || !link) s0 = ST_DISABLED;
        if (!alive) s0 = ST_IDLE;

        if (s0 == ST_DISABLED) xmit = i_cfg.sync_enable;

        // fall-through chain
        f_idle = ((s0 == ST_DISABLED) && i_cfg.sync_enable) || (s0 == ST_IDLE);
        f_la   = (f_idle && alive) || (s0 == ST_PEER_SEEN);
        f_cm   = (f_la && cfg_match) || (s0 == ST_CONFIG_MATCH);
        f_up   = f_cm && cfg_match && act_match;

        // config match lost drops back to the peer-seen state
        if (s0 == ST_UP)                  s_new = ST_UP;
        else if (f_up)                    s_new = ST_UP;
        else if (f_cm && cfg_match)       s_new = ST_CONFIG_MATCH;
        else if (f_la || f_cm)            s_new = ST_PEER_SEEN;
        else if (f_idle)                  s_new = ST_IDLE;
        else                              s_new = ST_DISABLED;

        if (f_cm && cfg_match && slave && cong && !la[BIT_RX]) lon = 1'b1;
        if (f_cm && cfg_match && master && cong) loff = 1'b1;

        if (i_core.tx_timer == '0) xmit = 1'b1;

        ev_core           = i_core;
        ev_core.state     = s_new;
        ev_core.alive     = alive;
        ev_core.local_act = la;
        ev_core.peer_act  = pa;
        ev_core.mode      = f_up ? 1'b1 : ((s0 == ST_UP) ? i_core.mode : 1'b0);

        ev_cmd            = '0;
        ev_cmd.lock_on    = lon;
        ev_cmd.lock_off   = loff;
        ev_cmd.entered_up = f_up;
        if ((s_new != ST_DISABLED) && xmit) begin
            ev_cmd.send      = 1'b1;
            ev_core.tx_timer = interval;
        end
    end

    always_comb begin
        o_core = i_core;
        o_cmd  = '0;
        case (i_item.func)
            FUNC_TICK: begin
                if (i_core.rx_timer != '0) o_core.rx_timer = i_core.rx_timer - 1'b1;
                if (i_core.tx_timer != '0) o_core.tx_timer = i_core.tx_timer - 1'b1;
            end
            FUNC_SIGNAL: begin
                o_core.rx_timer = rx_load;
                o_core.alive    = 1'b1;
                o_core.peer_cfg = i_item.peer_cfg;
                o_core.peer_act = i_item.peer_act;
            end
            FUNC_EVAL: begin
                o_core = ev_core;
                o_cmd  = ev_cmd;
            end
            default: begin
                o_core = i_core;
            end
        endcase
    end

endmodule

// ===== test/l1s_result_checker.sv =====
`timescale 1ns / 100ps
// Checker for the L1Sync port state machine: models the port, predicts and compares results.
module l1s_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [1:0]                     i_func,
    input  logic                           i_new_role,
    input  logic [1:0]                     i_port_role,
    input  logic                           i_link_up,
    input  logic                           i_pll_locked,
    input  logic                           i_peer_tx_cfg,
    input  logic                           i_peer_rx_cfg,
    input  logic                           i_peer_cong_cfg,
    input  logic                           i_peer_tx_act,
    input  logic                           i_peer_rx_act,
    input  logic                           i_peer_cong_act,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [2:0]                     i_sync_state,
    input  logic                           i_send_signal,
    input  logic                           i_pll_lock_on,
    input  logic                           i_pll_lock_off,
    input  logic                           i_accurate_mode,
    input  logic                           i_entered_up,
    input  logic                           i_tx_coh_active,
    input  logic                           i_rx_coh_active,
    input  logic                           i_cong_active,
    input  logic                           i_peer_alive,
    input  logic [17:0]                    i_next_delay,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [l1s_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [l1s_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);
    import l1s_pkg::*;

    typedef struct packed {
        logic [2:0]            sync_state;
        logic                  send_signal;
        logic                  pll_lock_on;
        logic                  pll_lock_off;
        logic                  accurate_mode;
        logic                  entered_up;
        logic                  tx_coh_active;
        logic                  rx_coh_active;
        logic                  cong_active;
        logic                  peer_alive;
        logic [TX_TIMER_W-1:0] next_delay;
    } t_port_result;

    t_cfg         cfg;
    t_core        core;
    t_item        item;
    t_port_result fresh, want;
    t_port_result awaited_results[$];

    function automatic logic [TX_TIMER_W-1:0] interval_ms(logic signed [3:0] lg);
        logic [TX_TIMER_W-1:0] base;
        int                    sh;
        base = TX_TIMER_W'(4);
        sh   = int'(lg) + 8;
        return base << sh;
    endfunction

    // one item against the port model; updates core, returns the result it causes
    task automatic step_port(input t_item it, output t_port_result r);
        logic       send, lon, loff, eup, xmit;
        logic       master, slave, cong, cfg_ok, st_ok, link_ok, done;
        logic [2:0] act;
        int         prod;
        send = 0; lon = 0; loff = 0; eup = 0; xmit = 0; done = 0;
        master = (it.port_role == ROLE_MASTER);
        slave  = (it.port_role == ROLE_SLAVE);
        cong   = cfg.local_cfg[BIT_CONG];
        case (it.func)
            FUNC_TICK: begin
                if (core.rx_timer != 0) core.rx_timer = core.rx_timer - 1'b1;
                if (core.tx_timer != 0) core.tx_timer = core.tx_timer - 1'b1;
            end
            FUNC_SIGNAL: begin
                prod = int'(interval_ms(cfg.log_interval)) * int'(cfg.receipt_timeout);
                core.rx_timer = RX_TIMER_W'(prod);
                core.alive    = 1;
                core.peer_cfg = it.peer_cfg;
                core.peer_act = it.peer_act;
            end
            FUNC_EVAL: begin
                act = core.local_act;
                if (it.new_role && cong) begin
                    xmit = 1;
                    if (master) begin
                        act[BIT_RX] = 0;
                        loff = 1;
                    end
                end
                if (core.alive && core.rx_timer == 0) begin
                    core.alive = 0;
                    if (slave) loff = 1;
                    xmit = 1;
                end
                if (slave && cong) begin
                    if (it.pll_locked) begin
                        if (!act[BIT_RX]) xmit = 1;
                        act[BIT_RX] = 1;
                    end else begin
                        act[BIT_RX] = 0;
                    end
                end
                if (master && cong)
                    act[BIT_RX] = core.peer_act[BIT_TX] && core.peer_act[BIT_RX] && act[BIT_TX];
                act[BIT_TX]    = it.link_up;
                act[BIT_CONG]  = it.link_up;
                core.local_act = act;
                if (core.state == ST_DISABLED || core.state == ST_IDLE) core.peer_act = '0;
                cfg_ok  = (cfg.local_cfg == core.peer_cfg);
                st_ok   = ((cfg.local_cfg & act & core.peer_act) == cfg.local_cfg);
                link_ok = core.alive;
                // disable override first, then loss of peer
                if (!cfg.sync_enable || !it.link_up) core.state = ST_DISABLED;
                if (!link_ok) core.state = ST_IDLE;
                // fall-through walk
                if (core.state == ST_DISABLED) begin
                    core.mode = 0;
                    xmit = 0;
                    if (!cfg.sync_enable) begin
                        done = 1;
                    end else begin
                        core.state = ST_IDLE;
                        xmit = 1;
                    end
                end
                if (!done && core.state == ST_IDLE) begin
                    core.mode = 0;
                    if (!link_ok) done = 1;
                    else core.state = ST_PEER_SEEN;
                end
                if (!done && core.state == ST_PEER_SEEN) begin
                    core.mode = 0;
                    if (!cfg_ok) done = 1;
                    else core.state = ST_CONFIG_MATCH;
                end
                if (!done && core.state == ST_CONFIG_MATCH) begin
                    core.mode = 0;
                    if (!cfg_ok) begin
                        core.state = ST_PEER_SEEN;
                    end else begin
                        if (slave && cong && !act[BIT_RX]) lon = 1;
                        if (master && cong) loff = 1;
                        if (st_ok) begin
                            core.state = ST_UP;
                            core.mode  = 1;
                            eup = 1;
                        end
                    end
                end
                if (core.tx_timer == 0) xmit = 1;
                if (core.state != ST_DISABLED && xmit) begin
                    core.tx_timer = interval_ms(cfg.log_interval);
                    send = 1;
                end
            end
            default: ;
        endcase
        r.sync_state    = core.state;
        r.send_signal   = send;
        r.pll_lock_on   = lon;
        r.pll_lock_off  = loff;
        r.accurate_mode = core.mode;
        r.entered_up    = eup;
        r.tx_coh_active = core.local_act[BIT_TX];
        r.rx_coh_active = core.local_act[BIT_RX];
        r.cong_active   = core.local_act[BIT_CONG];
        r.peer_alive    = core.alive;
        r.next_delay    = core.tx_timer;
    endtask

    function automatic int field_miss(string name, longint unsigned exp_v,
                                      longint unsigned got_v);
        if (exp_v == got_v) return 0;
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.sync_enable     = 1;
            cfg.local_cfg       = 3'b111;
            cfg.log_interval    = 0;
            cfg.receipt_timeout = 3;
            core       = '0;
            core.state = ST_DISABLED;
            awaited_results.delete();
            o_pending = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SYNC_ENABLE: cfg.sync_enable         = i_cfg_data[0];
                    CFG_TX_COH:      cfg.local_cfg[BIT_TX]   = i_cfg_data[0];
                    CFG_RX_COH:      cfg.local_cfg[BIT_RX]   = i_cfg_data[0];
                    CFG_CONGRUENT:   cfg.local_cfg[BIT_CONG] = i_cfg_data[0];
                    CFG_LOG_INTVL:   cfg.log_interval        = i_cfg_data[3:0];
                    CFG_RX_TIMEOUT:  cfg.receipt_timeout     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                item.func                = i_func;
                item.new_role            = i_new_role;
                item.port_role           = i_port_role;
                item.link_up             = i_link_up;
                item.pll_locked          = i_pll_locked;
                item.peer_cfg[BIT_TX]    = i_peer_tx_cfg;
                item.peer_cfg[BIT_RX]    = i_peer_rx_cfg;
                item.peer_cfg[BIT_CONG]  = i_peer_cong_cfg;
                item.peer_act[BIT_TX]    = i_peer_tx_act;
                item.peer_act[BIT_RX]    = i_peer_rx_act;
                item.peer_act[BIT_CONG]  = i_peer_cong_act;
                step_port(item, fresh);
                awaited_results.push_back(fresh);
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    o_errors = o_errors + 1;
                end else begin
                    want = awaited_results.pop_front();
                    o_errors = o_errors
                        + field_miss("sync_state", want.sync_state, i_sync_state)
                        + field_miss("send_signal", want.send_signal, i_send_signal)
                        + field_miss("pll_lock_on", want.pll_lock_on, i_pll_lock_on)
                        + field_miss("pll_lock_off", want.pll_lock_off, i_pll_lock_off)
                        + field_miss("accurate_mode", want.accurate_mode, i_accurate_mode)
                        + field_miss("entered_up", want.entered_up, i_entered_up)
                        + field_miss("tx_coh_active", want.tx_coh_active, i_tx_coh_active)
                        + field_miss("rx_coh_active", want.rx_coh_active, i_rx_coh_active)
                        + field_miss("cong_active", want.cong_active, i_cong_active)
                        + field_miss("peer_alive", want.peer_alive, i_peer_alive)
                        + field_miss("next_delay", want.next_delay, i_next_delay);
                end
            end
            o_pending = awaited_results.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the L1Sync port state machine: stimulus, stalls and verdict.
module tb_top;
    import l1s_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] FUNC_NONE     = 2'd3;   // unused function code, no-op
    localparam logic [1:0] ROLE_OTHER    = 2'd0;
    localparam logic [1:0] ROLE_SPARE    = 2'd3;   // behaves as other
    localparam logic [2:0] CFG_IDX_SPARE = 3'd7;   // no register behind it

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 160;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 10;    // quiet time after the last result
    localparam int CYCLE_LIMIT  = 100000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_func;
    logic                  i_new_role;
    logic [1:0]            i_port_role;
    logic                  i_link_up;
    logic                  i_pll_locked;
    logic                  i_peer_tx_cfg;
    logic                  i_peer_rx_cfg;
    logic                  i_peer_cong_cfg;
    logic                  i_peer_tx_act;
    logic                  i_peer_rx_act;
    logic                  i_peer_cong_act;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [2:0]            o_sync_state;
    logic                  o_send_signal;
    logic                  o_pll_lock_on;
    logic                  o_pll_lock_off;
    logic                  o_accurate_mode;
    logic                  o_entered_up;
    logic                  o_tx_coh_active;
    logic                  o_rx_coh_active;
    logic                  o_cong_active;
    logic                  o_peer_alive;
    logic [17:0]           o_next_delay;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int       errors;
    int       pending;
    int       cycles;
    int       hold_cycles;   // set by stimulus, counted down by the receiver
    bit       calm;          // no idling on either side while set
    logic [2:0] phase_cfg;   // local configured bits now in the block

    l1sync_port_state_machine uut (.*);

    l1s_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_new_role      (i_new_role),
        .i_port_role     (i_port_role),
        .i_link_up       (i_link_up),
        .i_pll_locked    (i_pll_locked),
        .i_peer_tx_cfg   (i_peer_tx_cfg),
        .i_peer_rx_cfg   (i_peer_rx_cfg),
        .i_peer_cong_cfg (i_peer_cong_cfg),
        .i_peer_tx_act   (i_peer_tx_act),
        .i_peer_rx_act   (i_peer_rx_act),
        .i_peer_cong_act (i_peer_cong_act),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_sync_state    (o_sync_state),
        .i_send_signal   (o_send_signal),
        .i_pll_lock_on   (o_pll_lock_on),
        .i_pll_lock_off  (o_pll_lock_off),
        .i_accurate_mode (o_accurate_mode),
        .i_entered_up    (o_entered_up),
        .i_tx_coh_active (o_tx_coh_active),
        .i_rx_coh_active (o_rx_coh_active),
        .i_cong_active   (o_cong_active),
        .i_peer_alive    (o_peer_alive),
        .i_next_delay    (o_next_delay),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake or a lost result ends here
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // Result side: random stalls, none while calm, and one long hold-off
    // on request so the two internal stages fill and input ready drops.
    initial begin
        i_out_ready = 1'b0;
        hold_cycles = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles--;
            end else begin
                i_out_ready <= calm || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    function automatic t_item item_of(logic [1:0] f, logic nr, logic [1:0] role, logic lk,
                                      logic pl, logic [2:0] pc, logic [2:0] pa);
        t_item it;
        it.func       = f;
        it.new_role   = nr;
        it.port_role  = role;
        it.link_up    = lk;
        it.pll_locked = pl;
        it.peer_cfg   = pc;
        it.peer_act   = pa;
        return it;
    endfunction

    // Mostly plausible traffic: link up, peer configured like us and fully
    // active, so the walk gets past the peer-seen state. About one in ten
    // is raw noise.
    function automatic t_item random_item();
        t_item it;
        int    pick;
        it   = t_item'($bits(t_item)'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 10) return it;
        it.func = (pick < 45) ? FUNC_TICK :
                  (pick < 62) ? FUNC_SIGNAL :
                  (pick < 95) ? FUNC_EVAL : FUNC_NONE;
        it.new_role   = ($urandom_range(0, 3) == 0);
        it.port_role  = 2'($urandom_range(0, 3));
        it.link_up    = ($urandom_range(0, 9) != 0);
        it.pll_locked = ($urandom_range(0, 9) < 7);
        if ($urandom_range(0, 4) != 0) it.peer_cfg = phase_cfg;
        if ($urandom_range(0, 4) != 0) it.peer_act = 3'b111;
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer,
    // valid still high so a following item keeps it up without a dip.
    task automatic send_item(input t_item it);
        while (!calm && $urandom_range(0, 99) < 25) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= it.func;
        i_new_role      <= it.new_role;
        i_port_role     <= it.port_role;
        i_link_up       <= it.link_up;
        i_pll_locked    <= it.pll_locked;
        i_peer_tx_cfg   <= it.peer_cfg[BIT_TX];
        i_peer_rx_cfg   <= it.peer_cfg[BIT_RX];
        i_peer_cong_cfg <= it.peer_cfg[BIT_CONG];
        i_peer_tx_act   <= it.peer_act[BIT_TX];
        i_peer_rx_act   <= it.peer_act[BIT_RX];
        i_peer_cong_act <= it.peer_act[BIT_CONG];
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every expected result has been taken
    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        if (last) i_cfg_valid <= 1'b0;
    endtask

    // full register set, written only with the block idle; unused data bits random
    task automatic program_port(input logic en, input logic [2:0] lc,
                                input logic signed [3:0] lg, input logic [7:0] tmo);
        settle();
        phase_cfg = lc;
        write_reg(CFG_SYNC_ENABLE, {7'($urandom), en}, 1'b0);
        write_reg(CFG_TX_COH, {7'($urandom), lc[BIT_TX]}, 1'b0);
        write_reg(CFG_RX_COH, {7'($urandom), lc[BIT_RX]}, 1'b0);
        write_reg(CFG_CONGRUENT, {7'($urandom), lc[BIT_CONG]}, 1'b0);
        write_reg(CFG_LOG_INTVL, {4'($urandom), lg}, 1'b0);
        write_reg(CFG_RX_TIMEOUT, tmo, 1'b1);
    endtask

    initial begin
        logic signed [3:0] lg;
        logic [2:0]        lc;

        // everything known from time zero, reset held low at the start
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_func          = FUNC_TICK;
        i_new_role      = 1'b0;
        i_port_role     = ROLE_OTHER;
        i_link_up       = 1'b0;
        i_pll_locked    = 1'b0;
        i_peer_tx_cfg   = 1'b0;
        i_peer_rx_cfg   = 1'b0;
        i_peer_cong_cfg = 1'b0;
        i_peer_tx_act   = 1'b0;
        i_peer_rx_act   = 1'b0;
        i_peer_cong_act = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_SYNC_ENABLE;
        i_cfg_data      = '0;
        calm            = 1'b0;
        phase_cfg       = 3'b111;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed, reset settings: enabled, all configured, 1024 ms interval
        send_item(item_of(FUNC_EVAL, 0, ROLE_OTHER, 0, 0, 3'b000, 3'b000));  // link down
        send_item(item_of(FUNC_NONE, 1, ROLE_SPARE, 1, 1, 3'b111, 3'b111));  // unused code
        send_item(item_of(FUNC_TICK, 1, ROLE_SLAVE, 1, 1, 3'b111, 3'b111));  // peer bits ignored
        send_item(item_of(FUNC_SIGNAL, 0, ROLE_OTHER, 0, 0, 3'b111, 3'b111));
        send_item(item_of(FUNC_EVAL, 1, ROLE_SLAVE, 1, 0, 3'b000, 3'b000));  // unlocked slave
        send_item(item_of(FUNC_EVAL, 0, ROLE_SLAVE, 1, 1, 3'b010, 3'b101));  // lock gained
        send_item(item_of(FUNC_EVAL, 1, ROLE_MASTER, 1, 1, 3'b000, 3'b000)); // role change
        send_item(item_of(FUNC_EVAL, 0, ROLE_SPARE, 1, 1, 3'b000, 3'b000));  // role three
        send_item(item_of(FUNC_EVAL, 0, ROLE_MASTER, 0, 1, 3'b111, 3'b111)); // link lost
        send_item(item_of(FUNC_SIGNAL, 1, ROLE_MASTER, 1, 1, 3'b000, 3'b000));
        send_item(item_of(FUNC_EVAL, 0, ROLE_MASTER, 1, 0, 3'b111, 3'b111)); // config mismatch

        // disabled: the disable override, no send
        program_port(1'b0, 3'b111, 4'sd0, 8'd3);
        send_item(item_of(FUNC_SIGNAL, 0, ROLE_OTHER, 1, 1, 3'b111, 3'b111));
        send_item(item_of(FUNC_EVAL, 0, ROLE_SLAVE, 1, 1, 3'b000, 3'b000));
        send_item(item_of(FUNC_EVAL, 1, ROLE_MASTER, 0, 0, 3'b000, 3'b000));

        // nothing configured, receipt timeout zero: peer lost at once
        program_port(1'b1, 3'b000, -4'sd8, 8'd0);
        send_item(item_of(FUNC_SIGNAL, 0, ROLE_OTHER, 1, 1, 3'b000, 3'b000));
        send_item(item_of(FUNC_EVAL, 0, ROLE_SLAVE, 1, 1, 3'b111, 3'b111));
        send_item(item_of(FUNC_SIGNAL, 0, ROLE_OTHER, 1, 1, 3'b000, 3'b000));
        // run the 4 ms transmit timer out, then evaluate
        repeat (5) send_item(item_of(FUNC_TICK, 0, ROLE_OTHER, 1, 1, 3'b000, 3'b000));
        send_item(item_of(FUNC_EVAL, 0, ROLE_SLAVE, 1, 1, 3'b000, 3'b000));

        // a write to an index with no register behind it
        settle();
        write_reg(CFG_IDX_SPARE, 8'hff, 1'b1);

        // --- random phases: two extreme settings, one disabled, the rest short timers and mostly enabled
        for (int ph = 0; ph < PHASES; ph++) begin
            lg = 4'($urandom_range(8, 11));   // -8 .. -5: timers expire under ticks
            lc = $urandom_range(0, 1) ? 3'b111 : 3'($urandom);
            case (ph)
                0:       program_port(1'b1, 3'b111, -4'sd8, 8'd1);
                1:       program_port(1'b1, 3'b111, 4'sd7, 8'd255);
                2:       program_port(1'b0, lc, lg, 8'($urandom_range(0, 4)));
                default: program_port($urandom_range(0, 7) != 0, lc, lg,
                                      8'($urandom_range(0, 6)));
            endcase
            calm = (ph == 4);   // one long stretch without idling
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == 20) hold_cycles = HOLD_CYCLES;
                send_item(random_item());
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
